@@ hdl/tc_pkg.sv @@
// Shared types and codes for the triangle classifier pipeline.
// Holds the field widths, the stage payload structs and the class codes.
// Depends on nothing; every other file refers to it by scoped names.
package tc_pkg;

  localparam int COORD_W = 31;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic        [PROD_W-1:0]  sq_t;

  typedef enum logic [1:0] {
    SIDE_SCALENE,
    SIDE_ISOSCELES,
    SIDE_EQUILATERAL
  } side_class_t;

  typedef enum logic [1:0] {
    ANGLE_ACUTE,
    ANGLE_RIGHT,
    ANGLE_OBTUSE
  } angle_class_t;

  // Three input points as one word.
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by_coord;
    coord_t cx;
    coord_t cy;
  } pts_t;

  // Edge vectors AB, BC and CA.
  typedef struct packed {
    diff_t dx_ab;
    diff_t dy_ab;
    diff_t dx_bc;
    diff_t dy_bc;
    diff_t dx_ca;
    diff_t dy_ca;
  } edges_t;

  // Cross product terms and squared edge components.
  typedef struct packed {
    prod_t cr1;
    prod_t cr2;
    sq_t   sqx_ab;
    sq_t   sqy_ab;
    sq_t   sqx_bc;
    sq_t   sqy_bc;
    sq_t   sqx_ca;
    sq_t   sqy_ca;
  } prods_t;

  // Squared side lengths and the collinear flag.
  typedef struct packed {
    logic collinear;
    sq_t  s0;
    sq_t  s1;
    sq_t  s2;
  } sides_t;

  // Side class plus the two shorter and the longest squared side.
  typedef struct packed {
    logic        valid_tri;
    side_class_t side;
    logic        have_max;
    sq_t         a;
    sq_t         b;
    sq_t         c;
  } sel_t;

  // Final result item.
  typedef struct packed {
    logic         valid_triangle;
    side_class_t  side_class;
    angle_class_t angle_class;
  } res_t;

endpackage

@@ hdl/tc_ifs.sv @@
// Valid/ready channel interfaces for the triangle classifier.
// tc_in_if carries one point triple, tc_out_if one classification item.
// Depends on tc_pkg for the field types.
interface tc_in_if;
  logic            valid;
  logic            ready;
  tc_pkg::coord_t  ax;
  tc_pkg::coord_t  ay;
  tc_pkg::coord_t  bx;
  tc_pkg::coord_t  by_coord;
  tc_pkg::coord_t  cx;
  tc_pkg::coord_t  cy;

  modport source (output valid, ax, ay, bx, by_coord, cx, cy, input ready);
  modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

interface tc_out_if;
  logic       valid;
  logic       ready;
  logic       valid_triangle;
  logic [1:0] side_class;
  logic [1:0] angle_class;

  modport source (output valid, valid_triangle, side_class, angle_class, input ready);
  modport sink   (input valid, valid_triangle, side_class, angle_class, output ready);
endinterface

@@ hdl/tc_diff.sv @@
// Stage 1 of the classifier: edge vectors of the triangle.
// Registers AB, BC and CA as 32-bit signed differences.
// Depends on tc_pkg.
module tc_diff (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  tc_pkg::pts_t    up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output tc_pkg::edges_t  dn_data
);

  logic           vld_r;
  logic           adv;
  tc_pkg::edges_t data_r;
  tc_pkg::edges_t data_nxt;

  always_comb begin
    data_nxt.dx_ab = tc_pkg::DIFF_W'(up_data.bx) - tc_pkg::DIFF_W'(up_data.ax);
    data_nxt.dy_ab = tc_pkg::DIFF_W'(up_data.by_coord) - tc_pkg::DIFF_W'(up_data.ay);
    data_nxt.dx_bc = tc_pkg::DIFF_W'(up_data.cx) - tc_pkg::DIFF_W'(up_data.bx);
    data_nxt.dy_bc = tc_pkg::DIFF_W'(up_data.cy) - tc_pkg::DIFF_W'(up_data.by_coord);
    data_nxt.dx_ca = tc_pkg::DIFF_W'(up_data.ax) - tc_pkg::DIFF_W'(up_data.cx);
    data_nxt.dy_ca = tc_pkg::DIFF_W'(up_data.ay) - tc_pkg::DIFF_W'(up_data.cy);
  end

  // The stage takes a new item when it is empty or its item moves on.
  assign adv      = !vld_r || dn_ready;
  assign up_ready = adv;
  assign dn_valid = vld_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ hdl/tc_mul.sv @@
// Stage 2 of the classifier: eight 32x32 signed products in parallel.
// Two cross product terms for the area test and six squared components.
// Depends on tc_pkg.
module tc_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  tc_pkg::edges_t  up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output tc_pkg::prods_t  dn_data
);

  logic           vld_r;
  logic           adv;
  tc_pkg::prods_t data_r;
  tc_pkg::prods_t data_nxt;

  // Twice the area is (B-A)x(C-A); with C-A = -CA the signs cancel, so the
  // points are collinear exactly when dx_ab*dy_ca equals dy_ab*dx_ca.
  always_comb begin
    data_nxt.cr1    = tc_pkg::prod_t'(up_data.dx_ab) * tc_pkg::prod_t'(up_data.dy_ca);
    data_nxt.cr2    = tc_pkg::prod_t'(up_data.dy_ab) * tc_pkg::prod_t'(up_data.dx_ca);
    data_nxt.sqx_ab = tc_pkg::sq_t'(tc_pkg::prod_t'(up_data.dx_ab)
                                    * tc_pkg::prod_t'(up_data.dx_ab));
    data_nxt.sqy_ab = tc_pkg::sq_t'(tc_pkg::prod_t'(up_data.dy_ab)
                                    * tc_pkg::prod_t'(up_data.dy_ab));
    data_nxt.sqx_bc = tc_pkg::sq_t'(tc_pkg::prod_t'(up_data.dx_bc)
                                    * tc_pkg::prod_t'(up_data.dx_bc));
    data_nxt.sqy_bc = tc_pkg::sq_t'(tc_pkg::prod_t'(up_data.dy_bc)
                                    * tc_pkg::prod_t'(up_data.dy_bc));
    data_nxt.sqx_ca = tc_pkg::sq_t'(tc_pkg::prod_t'(up_data.dx_ca)
                                    * tc_pkg::prod_t'(up_data.dx_ca));
    data_nxt.sqy_ca = tc_pkg::sq_t'(tc_pkg::prod_t'(up_data.dy_ca)
                                    * tc_pkg::prod_t'(up_data.dy_ca));
  end

  assign adv      = !vld_r || dn_ready;
  assign up_ready = adv;
  assign dn_valid = vld_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ hdl/tc_sum.sv @@
// Stage 3 of the classifier: squared side lengths and the collinear test.
// Each side is the sum of two squares and stays below 2^63.
// Depends on tc_pkg.
module tc_sum (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  tc_pkg::prods_t  up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output tc_pkg::sides_t  dn_data
);

  logic           vld_r;
  logic           adv;
  tc_pkg::sides_t data_r;
  tc_pkg::sides_t data_nxt;

  always_comb begin
    data_nxt.collinear = (up_data.cr1 == up_data.cr2);
    data_nxt.s0        = up_data.sqx_ab + up_data.sqy_ab;
    data_nxt.s1        = up_data.sqx_bc + up_data.sqy_bc;
    data_nxt.s2        = up_data.sqx_ca + up_data.sqy_ca;
  end

  assign adv      = !vld_r || dn_ready;
  assign up_ready = adv;
  assign dn_valid = vld_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ hdl/tc_class.sv @@
// Stages 4 and 5 of the classifier: side equality, longest side selection
// and the angle test against the longest side. Stage 5 is the output register.
// Depends on tc_pkg.
module tc_class (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  tc_pkg::sides_t  up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output tc_pkg::res_t    dn_data
);

  logic           sel_vld_r;
  logic           sel_adv;
  tc_pkg::sel_t   sel_r;
  tc_pkg::sel_t   sel_nxt;

  logic           res_vld_r;
  logic           res_adv;
  tc_pkg::res_t   res_r;
  tc_pkg::res_t   res_nxt;

  logic           gt01, gt02, gt10, gt12, gt20, gt21;
  logic           eq01, eq12, eq02;
  tc_pkg::sq_t    rest;

  // Stage 4: compare the three sides, classify by equality and order them.
  always_comb begin
    gt01 = up_data.s0 > up_data.s1;
    gt02 = up_data.s0 > up_data.s2;
    gt10 = up_data.s1 > up_data.s0;
    gt12 = up_data.s1 > up_data.s2;
    gt20 = up_data.s2 > up_data.s0;
    gt21 = up_data.s2 > up_data.s1;
    eq01 = up_data.s0 == up_data.s1;
    eq12 = up_data.s1 == up_data.s2;
    eq02 = up_data.s0 == up_data.s2;

    sel_nxt.valid_tri = !up_data.collinear;
    sel_nxt.have_max  = 1'b1;
    sel_nxt.a         = '0;
    sel_nxt.b         = '0;
    sel_nxt.c         = '0;

    if (up_data.collinear) begin
      sel_nxt.side = tc_pkg::SIDE_SCALENE;
    end else if (eq01 && eq02) begin
      sel_nxt.side = tc_pkg::SIDE_EQUILATERAL;
    end else if (eq01 || eq12 || eq02) begin
      sel_nxt.side = tc_pkg::SIDE_ISOSCELES;
    end else begin
      sel_nxt.side = tc_pkg::SIDE_SCALENE;
    end

    if (gt01 && gt02) begin
      sel_nxt.a = up_data.s1;
      sel_nxt.b = up_data.s2;
      sel_nxt.c = up_data.s0;
    end else if (gt10 && gt12) begin
      sel_nxt.a = up_data.s0;
      sel_nxt.b = up_data.s2;
      sel_nxt.c = up_data.s1;
    end else if (gt20 && gt21) begin
      sel_nxt.a = up_data.s0;
      sel_nxt.b = up_data.s1;
      sel_nxt.c = up_data.s2;
    end else begin
      // No strictly longest side: the triangle counts as acute.
      sel_nxt.have_max = 1'b0;
    end
  end

  // Stage 5: a + b against c, done as b against c - a so nothing overflows.
  always_comb begin
    rest                   = sel_r.c - sel_r.a;
    res_nxt.valid_triangle = sel_r.valid_tri;
    res_nxt.side_class     = sel_r.side;
    if (!sel_r.valid_tri || !sel_r.have_max) begin
      res_nxt.angle_class = tc_pkg::ANGLE_ACUTE;
    end else if (sel_r.b < rest) begin
      res_nxt.angle_class = tc_pkg::ANGLE_OBTUSE;
    end else if (sel_r.b > rest) begin
      res_nxt.angle_class = tc_pkg::ANGLE_ACUTE;
    end else begin
      res_nxt.angle_class = tc_pkg::ANGLE_RIGHT;
    end
  end

  assign res_adv  = !res_vld_r || dn_ready;
  assign sel_adv  = !sel_vld_r || res_adv;
  assign up_ready = sel_adv;
  assign dn_valid = res_vld_r;
  assign dn_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (sel_adv) begin
        sel_vld_r <= up_valid;
      end
      if (res_adv) begin
        res_vld_r <= sel_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel_adv && up_valid) begin
      sel_r <= sel_nxt;
    end
    if (res_adv && sel_vld_r) begin
      res_r <= res_nxt;
    end
  end

endmodule

@@ hdl/triangle_classifier.sv @@
// Top level of the triangle classifier: five-stage valid/ready pipeline.
// Instantiates tc_diff, tc_mul, tc_sum and tc_class; uses tc_pkg and tc_ifs.
//
//   Channel   Dir  Interface  Payload
//   in_pts    in   tc_in_if   ax, ay, bx, by_coord, cx, cy (31-bit signed)
//   out_res   out  tc_out_if  valid_triangle, side_class, angle_class
//
// One item is accepted per cycle while the output side keeps ready high, and
// each item passes the register of every stage in turn. The depth is set by the
// 32x32 multipliers in stage 2 and the 64-bit compares of stages 4 and 5.
// Reset (rst_n, synchronous, active low) empties all five stages.
// When out_res.ready is low the result is held in the output register and the
// earlier stages keep filling their empty slots, so in_pts.ready drops only
// once every stage holds an item.
module triangle_classifier (
  input  logic      clk,
  input  logic      rst_n,
  tc_in_if.sink     in_pts,
  tc_out_if.source  out_res
);

  tc_pkg::pts_t    pts;
  tc_pkg::edges_t  edges;
  tc_pkg::prods_t  prods;
  tc_pkg::sides_t  sides;
  tc_pkg::res_t    res;

  logic edges_valid, edges_ready;
  logic prods_valid, prods_ready;
  logic sides_valid, sides_ready;

  always_comb begin
    pts.ax       = in_pts.ax;
    pts.ay       = in_pts.ay;
    pts.bx       = in_pts.bx;
    pts.by_coord = in_pts.by_coord;
    pts.cx       = in_pts.cx;
    pts.cy       = in_pts.cy;
  end

  // Stage 1: edge vectors.
  tc_diff u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_pts.valid),
    .up_ready (in_pts.ready),
    .up_data  (pts),
    .dn_valid (edges_valid),
    .dn_ready (edges_ready),
    .dn_data  (edges)
  );

  // Stage 2: cross product terms and squared components.
  tc_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (edges_valid),
    .up_ready (edges_ready),
    .up_data  (edges),
    .dn_valid (prods_valid),
    .dn_ready (prods_ready),
    .dn_data  (prods)
  );

  // Stage 3: squared sides and the collinear flag.
  tc_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prods_valid),
    .up_ready (prods_ready),
    .up_data  (prods),
    .dn_valid (sides_valid),
    .dn_ready (sides_ready),
    .dn_data  (sides)
  );

  // Stages 4 and 5: side class, longest side, angle class, output register.
  tc_class u_class (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sides_valid),
    .up_ready (sides_ready),
    .up_data  (sides),
    .dn_valid (out_res.valid),
    .dn_ready (out_res.ready),
    .dn_data  (res)
  );

  assign out_res.valid_triangle = res.valid_triangle;
  assign out_res.side_class     = res.side_class;
  assign out_res.angle_class    = res.angle_class;

  // A degenerate triangle always reports the zero classes.
  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.valid_triangle) |->
      (out_res.side_class == tc_pkg::SIDE_SCALENE &&
       out_res.angle_class == tc_pkg::ANGLE_ACUTE))
    else $error("degenerate triangle with nonzero class");

  // An equilateral result must come from a real triangle and be acute.
  a_equilateral_acute: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.side_class == tc_pkg::SIDE_EQUILATERAL) |->
      (out_res.valid_triangle && out_res.angle_class == tc_pkg::ANGLE_ACUTE))
    else $error("equilateral triangle not classified as acute");

  // Reset empties the pipeline, so no result is offered right after it.
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_res.valid)
    else $error("result offered right after reset");

endmodule
